// File: sv/fmtpc_pkg.sv
// fmtpc_pkg: types and constants shared by the frame test-pattern checker
// used by fmtpc_cfg, fmtpc_track and frame_test_pattern_checker
package fmtpc_pkg;

    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int HALF_W    = 16;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_CAP       = 13'd4096;
    localparam logic [COUNT_W-1:0] ROW_COUNT_RST   = 13'd2048;
    localparam logic [COUNT_W-1:0] WORDS_ROW_RST   = 13'd1024;
    localparam logic [HALF_W-1:0]  PAIR_START      = 16'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT     = 1'b0,
        REG_WORDS_PER_ROW = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rows;
        logic [COUNT_W-1:0] wpr;
    } counts_t;

    typedef struct packed {
        logic               word_ok;
        logic [WORD_W-1:0]  expected_word;
        logic [INDEX_W-1:0] line_number;
        logic               frame_end;
        logic               frame_pass;
        logic [HALF_W-1:0]  frame_number;
        logic               frame_number_wrong;
    } result_t;

endpackage

// File: sv/frame_test_pattern_checker.sv
// frame_test_pattern_checker: top level with input and result registers
// depends on fmtpc_pkg, fmtpc_cfg, fmtpc_track
//
// Usage:
//   stream channel (stream_valid, stream_stall, stream_word) carries one
//   32-bit word per item; an item is taken when valid is high and stall low.
//   result channel (result_valid, result_stall and the result fields) gives
//   one result item per input item, in order.
//   config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   row_count (index 0) or words_per_row (index 1); cfg_ready is always high.
//   Write configuration only while no item is in flight.
// Datapath: each item passes the input register, then compare logic
//   into the result register.
// Throughput: one item per cycle while results are not stalled; the input
//   register and the result register form a two-entry pipeline.
// Stall: with result_stall high the result holds; if the input register is
//   empty one more item is taken into it, then stream_stall rises.
// Reset: both pipeline stages empty, counts 2048 lines and 1024 words,
//   the first frame number seen is adopted as the expected one.
module frame_test_pattern_checker #(
    parameter int MAX_LINES          = 4096,
    parameter int MAX_WORDS_PER_LINE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stream_valid,
    output logic                            stream_stall,
    input  logic [fmtpc_pkg::WORD_W-1:0]    stream_word,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            word_ok,
    output logic [fmtpc_pkg::WORD_W-1:0]    expected_word,
    output logic [fmtpc_pkg::INDEX_W-1:0]   line_number,
    output logic                            frame_end,
    output logic                            frame_pass,
    output logic [fmtpc_pkg::HALF_W-1:0]    frame_number,
    output logic                            frame_number_wrong,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fmtpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fmtpc_pkg::COUNT_W-1:0]   cfg_data
);
    import fmtpc_pkg::*;

    localparam logic [COUNT_W-1:0] LINE_LIM =
        (MAX_LINES < 4096) ? COUNT_W'(MAX_LINES) : COUNT_CAP;
    localparam logic [COUNT_W-1:0] WORD_LIM =
        (MAX_WORDS_PER_LINE < 4096) ? COUNT_W'(MAX_WORDS_PER_LINE) : COUNT_CAP;

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              res_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    counts_t           counts;
    logic              load_res;
    logic              advance;
    logic              take_in;

    assign cfg_ready    = 1'b1;
    assign load_res     = !res_valid_reg || !result_stall;
    assign advance      = in_valid_reg && load_res;
    assign stream_stall = in_valid_reg && !load_res;
    assign take_in      = stream_valid && !stream_stall;

    fmtpc_cfg #(
        .LINE_LIM (LINE_LIM),
        .WORD_LIM (WORD_LIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .counts    (counts)
    );

    fmtpc_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_word_reg),
        .counts  (counts),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (load_res)
                res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_word_reg <= stream_word;
        if (advance)
            res_reg <= res_next;
    end

    assign result_valid       = res_valid_reg;
    assign word_ok            = res_reg.word_ok;
    assign expected_word      = res_reg.expected_word;
    assign line_number        = res_reg.line_number;
    assign frame_end          = res_reg.frame_end;
    assign frame_pass         = res_reg.frame_pass;
    assign frame_number       = res_reg.frame_number;
    assign frame_number_wrong = res_reg.frame_number_wrong;

    a_pass_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_pass |-> frame_end && word_ok)
        else $error("frame_pass without frame end or with a bad word");

    a_wrong_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_number_wrong |-> frame_end)
        else $error("frame_number_wrong outside frame end");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        stream_stall |-> in_valid_reg && result_valid && result_stall)
        else $error("input stalled while pipeline has room");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(expected_word))
        else $error("stalled result changed");

endmodule

// File: sv/fmtpc_cfg.sv
// fmtpc_cfg: row and word count registers with range clamping
// depends on fmtpc_pkg
module fmtpc_cfg #(
    parameter logic [12:0] LINE_LIM = 13'd4096,
    parameter logic [12:0] WORD_LIM = 13'd4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [fmtpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fmtpc_pkg::COUNT_W-1:0]   cfg_data,
    output fmtpc_pkg::counts_t              counts
);
    import fmtpc_pkg::*;

    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] words_per_row_reg;

    function automatic logic [COUNT_W-1:0] clamp(input logic [COUNT_W-1:0] v,
                                                 input logic [COUNT_W-1:0] lim);
        logic [COUNT_W-1:0] r;
        if (v == '0)
            r = 13'd1;
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= ROW_COUNT_RST;
            words_per_row_reg <= WORDS_ROW_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_COUNT:     row_count_reg     <= cfg_data;
                REG_WORDS_PER_ROW: words_per_row_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign counts.rows = clamp(row_count_reg, LINE_LIM);
    assign counts.wpr  = clamp(words_per_row_reg, WORD_LIM);

endmodule

// File: sv/fmtpc_track.sv
// fmtpc_track: frame, line and word position tracking and pattern compare
// depends on fmtpc_pkg
module fmtpc_track (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [fmtpc_pkg::WORD_W-1:0] word,
    input  fmtpc_pkg::counts_t           counts,
    output fmtpc_pkg::result_t           result
);
    import fmtpc_pkg::*;

    logic               awaiting_reg,   awaiting_next;
    logic [HALF_W-1:0]  expected_reg,   expected_next;
    logic [HALF_W-1:0]  received_reg,   received_next;
    logic [INDEX_W-1:0] line_reg,       line_next;
    logic [INDEX_W-1:0] windex_reg,     windex_next;
    logic [HALF_W-1:0]  pair_reg,       pair_next;
    logic               failed_reg,     failed_next;

    logic              first;
    logic              last_word;
    logic              last_line;
    logic              fend;
    logic              ok;
    logic [WORD_W-1:0] expect_w;

    always_comb
    begin
        first         = (windex_reg == '0) && (line_reg == '0);
        awaiting_next = awaiting_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        failed_next   = failed_reg;
        pair_next     = pair_reg;
        if (first)
        begin
            received_next = word[HALF_W-1:0];
            awaiting_next = 1'b0;
            failed_next   = 1'b0;
            if (awaiting_reg)
                expected_next = word[HALF_W-1:0];
            else
                expected_next = expected_reg + 16'd1;
        end
        if (windex_reg == '0)
            expect_w = {4'd0, line_reg, expected_next};
        else
        begin
            expect_w  = {pair_reg + 16'd1, pair_reg};
            pair_next = pair_reg + 16'd2;
        end
        ok = (expect_w == word);
        if (!ok)
            failed_next = 1'b1;
        last_word = ({1'b0, windex_reg} + 13'd1) >= counts.wpr;
        last_line = ({1'b0, line_reg} + 13'd1) >= counts.rows;
        fend      = last_word && last_line;
        line_next   = line_reg;
        windex_next = windex_reg + 12'd1;
        if (last_word)
        begin
            windex_next = '0;
            pair_next   = PAIR_START;
            line_next   = last_line ? '0 : line_reg + 12'd1;
        end
    end

    always_comb
    begin
        result.word_ok            = ok;
        result.expected_word      = expect_w;
        result.line_number        = line_reg;
        result.frame_end          = fend;
        result.frame_pass         = fend && !failed_next;
        result.frame_number       = expected_next;
        result.frame_number_wrong = fend && (received_next != expected_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            expected_reg <= '0;
            received_reg <= '0;
            line_reg     <= '0;
            windex_reg   <= '0;
            pair_reg     <= PAIR_START;
            failed_reg   <= 1'b0;
        end
        else if (advance)
        begin
            awaiting_reg <= awaiting_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            line_reg     <= line_next;
            windex_reg   <= windex_next;
            pair_reg     <= pair_next;
            failed_reg   <= failed_next;
        end
    end

endmodule
